/* rtl/lrupr_pkg.sv */
// Shared constants and result type for the LRU page replacement block.
`default_nettype none

package lrupr_pkg;

  localparam int PAGE_IN_W   = 16;
  localparam int FRAME_OUT_W = 2;
  localparam int FAULT_W     = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // Packed so that hit lands in the lowest bit.
  typedef struct packed {
    logic [FAULT_W-1:0]     fault_count;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   hit;
  } lrupr_result_t;

  localparam int RESULT_W = $bits(lrupr_result_t);

endpackage

`default_nettype wire

/* rtl/lrupr_select.sv */
// Frame selection: hit frame, lowest empty frame, or least recently used frame.
`default_nettype none

module lrupr_select
  import lrupr_pkg::*;
#(
  parameter int FRAME_COUNT = 3,
  localparam int IdxW = $clog2(FRAME_COUNT)
) (
  input  logic [FRAME_COUNT-1:0]           match_i,
  input  logic [FRAME_COUNT-1:0]           valid_i,
  input  logic [FRAME_COUNT-1:0][IdxW-1:0] rank_i,
  output logic                             hit_o,
  output logic                             fill_o,
  output logic [IdxW-1:0]                  target_o
);

  localparam logic [IdxW-1:0] OldestRank = IdxW'(FRAME_COUNT - 1);

  logic [IdxW-1:0] match_idx;
  logic [IdxW-1:0] empty_idx;
  logic [IdxW-1:0] lru_idx;

  // Scan from the top so the lowest-numbered candidate wins.
  always_comb begin
    match_idx = '0;
    empty_idx = '0;
    lru_idx   = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (match_i[i]) begin
        match_idx = IdxW'(i);
      end
      if (!valid_i[i]) begin
        empty_idx = IdxW'(i);
      end
      // With every frame valid the ranks are a permutation, so the oldest is unique.
      if (rank_i[i] == OldestRank) begin
        lru_idx = IdxW'(i);
      end
    end
  end

  assign hit_o  = |match_i;
  assign fill_o = !hit_o && !(&valid_i);

  always_comb begin
    if (hit_o) begin
      target_o = match_idx;
    end else if (fill_o) begin
      target_o = empty_idx;
    end else begin
      target_o = lru_idx;
    end
  end

endmodule

`default_nettype wire

/* rtl/lrupr_frames.sv */
// Frame table, recency ranks and fault counter, all updated together when enabled.
`default_nettype none

module lrupr_frames
  import lrupr_pkg::*;
#(
  parameter int FRAME_COUNT = 3,
  parameter int PAGE_BITS   = 16,
  localparam int KeyW = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [KeyW-1:0] page_i,
  output lrupr_result_t   result_o
);

  localparam int IdxW = $clog2(FRAME_COUNT);

  logic [FRAME_COUNT-1:0][KeyW-1:0] page_q;
  logic [FRAME_COUNT-1:0]           valid_q, valid_d;
  logic [FRAME_COUNT-1:0][IdxW-1:0] rank_q, rank_d;
  logic [FAULT_W-1:0]               fault_q, fault_d;

  logic [FRAME_COUNT-1:0] match;
  logic                   hit;
  logic                   fill;
  logic [IdxW-1:0]        target;
  logic [IdxW-1:0]        target_rank;

  always_comb begin
    for (int i = 0; i < FRAME_COUNT; i++) begin
      match[i] = valid_q[i] && (page_q[i] == page_i);
    end
  end

  lrupr_select #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_select (
    .match_i (match),
    .valid_i (valid_q),
    .rank_i  (rank_q),
    .hit_o   (hit),
    .fill_o  (fill),
    .target_o(target)
  );

  assign target_rank = rank_q[target];

  // Age every valid frame younger than the target; a fill ages all valid frames.
  always_comb begin
    valid_d = valid_q;
    valid_d[target] = 1'b1;
    for (int i = 0; i < FRAME_COUNT; i++) begin
      if (IdxW'(i) == target) begin
        rank_d[i] = '0;
      end else if (valid_q[i] && (fill || (rank_q[i] < target_rank))) begin
        rank_d[i] = rank_q[i] + IdxW'(1);
      end else begin
        rank_d[i] = rank_q[i];
      end
    end
  end

  assign fault_d = (!hit && (fault_q != FAULT_MAX)) ? fault_q + FAULT_W'(1) : fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '0;
      fault_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      fault_q <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !hit) begin
      page_q[target] <= page_i;
    end
  end

  assign result_o.hit         = hit;
  assign result_o.frame_index = FRAME_OUT_W'(target);
  assign result_o.fault_count = fault_d;

endmodule

`default_nettype wire

/* rtl/lru_page_replacement_top.sv */
// Top level of the LRU page replacement block: input and result registers.
//
// One page reference enters on the s_axis channel; one result leaves on the
// m_axis channel for every reference, in order. A result carries the hit flag,
// the frame now holding the page and the running fault count (saturating).
// The reference is registered in the input register when accepted; the frame
// compare, victim choice and recency update then run combinationally from it
// into the result register, loaded in the same cycle as the frame table.
// Throughput is one reference per cycle unless m_axis_tready stalls the
// result; all frames are compared in parallel and the table updates in the
// same cycle, so the next reference sees it.
// Reset empties all frames, clears the recency ranks and the fault counter,
// and drops any request in flight.
// When the receiver holds m_axis_tready low, the result register holds its
// value, the input register holds one more reference, and s_axis_tready
// falls once both are full.
`default_nettype none

module lru_page_replacement_top
  import lrupr_pkg::*;
#(
  parameter int FRAME_COUNT = 3,
  parameter int PAGE_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] page_number
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [0] hit, [2:1] frame_index,
                                                // [18:3] fault_count, [23:19] zero
);

  localparam int KeyW = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;

  logic            in_valid_q;
  logic [KeyW-1:0] in_page_q;
  logic            out_valid_q;
  lrupr_result_t   out_q;
  lrupr_result_t   result;
  logic            advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_page_q <= s_axis_tdata[KeyW-1:0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  lrupr_frames #(
    .FRAME_COUNT(FRAME_COUNT),
    .PAGE_BITS  (PAGE_BITS)
  ) u_frames (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .page_i  (in_page_q),
    .result_o(result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_q};

endmodule

`default_nettype wire

/* tb/tb_lru_page_replacement_top.sv */
// Self-checking testbench for the LRU page replacement block: stream stimulus and LRU predictor.
`timescale 1ns / 100ps

module tb_lru_page_replacement_top;
  import lrupr_pkg::*;

  localparam int NFRAMES     = 3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PRINT_LIMIT = 40;
  localparam int HOT_PAGES   = 5;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [15:0] page_number
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [0] hit, [2:1] frame_index,
                                              // [18:3] fault_count, [23:19] zero

  // Predicted frame table
  logic [PAGE_IN_W-1:0]   frame_tag  [NFRAMES];
  logic                   frame_used [NFRAMES];
  logic [1:0]             frame_age  [NFRAMES];
  logic [FAULT_W-1:0]     fault_total;
  lrupr_result_t          lookup_results_q [$];

  logic [PAGE_IN_W-1:0]   hot_page [HOT_PAGES];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_until = 0;
  int unsigned held_cycles    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  lru_page_replacement_top #(
    .FRAME_COUNT(NFRAMES),
    .PAGE_BITS  (PAGE_IN_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hit, fill of the lowest empty frame, or eviction of the oldest frame.
  function automatic lrupr_result_t lru_access(input logic [PAGE_IN_W-1:0] page);
    lrupr_result_t res;
    int            target;
    bit            found;
    bit            free_slot;
    logic [1:0]    oldest;
    logic [1:0]    old_rank;
    target    = 0;
    found     = 1'b0;
    free_slot = 1'b0;
    for (int i = 0; i < NFRAMES; i++) begin
      if (!found && frame_used[i] && frame_tag[i] == page) begin
        target = i;
        found  = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < NFRAMES; i++) begin
        if (!free_slot && !frame_used[i]) begin
          target    = i;
          free_slot = 1'b1;
        end
      end
      if (!free_slot) begin
        oldest = '0;
        target = 0;
        for (int i = 0; i < NFRAMES; i++) begin
          if (frame_age[i] > oldest) begin
            oldest = frame_age[i];
            target = i;
          end
        end
      end
    end
    // An empty frame counts as older than every resident one.
    old_rank = (found || !free_slot) ? frame_age[target] : 2'(NFRAMES);
    for (int i = 0; i < NFRAMES; i++) begin
      if (i != target && frame_used[i] && frame_age[i] < old_rank) frame_age[i]++;
    end
    frame_age[target] = '0;
    if (!found) begin
      frame_used[target] = 1'b1;
      frame_tag[target]  = page;
      if (fault_total != FAULT_MAX) fault_total++;
    end
    res.hit         = found;
    res.frame_index = FRAME_OUT_W'(target);
    res.fault_count = fault_total;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    lrupr_result_t got;
    lrupr_result_t want;
    got = data[RESULT_W-1:0];
    if (lookup_results_q.size() == 0) begin
      report_mismatch("result with no pending request", 32'(data), 32'h0);
    end else begin
      want = lookup_results_q.pop_front();
      if (got.hit !== want.hit) report_mismatch("hit", 32'(got.hit), 32'(want.hit));
      if (got.frame_index !== want.frame_index)
        report_mismatch("frame_index", 32'(got.frame_index), 32'(want.frame_index));
      if (got.fault_count !== want.fault_count)
        report_mismatch("fault_count", 32'(got.fault_count), 32'(want.fault_count));
      if (data[OUT_DATA_W-1:RESULT_W] !== '0)
        report_mismatch("tdata padding", 32'(data[OUT_DATA_W-1:RESULT_W]), 32'h0);
    end
  endtask

  // Receiver: check accepted results, stall at random, honor long hold-offs.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if (held_cycles < hold_off_until) begin
      held_cycles++;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_page(input logic [PAGE_IN_W-1:0] page);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lookup_results_q.push_back(lru_access(page));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (lookup_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic refresh_hot_pages();
    foreach (hot_page[i]) hot_page[i] = PAGE_IN_W'($urandom);
  endtask

  // Mostly a small working set so hits and evictions both happen often.
  function automatic logic [PAGE_IN_W-1:0] pick_page();
    int unsigned sel;
    logic [PAGE_IN_W-1:0] page;
    sel  = $urandom_range(99);
    page = hot_page[$urandom_range(HOT_PAGES - 1)];
    if (sel >= 85) page = PAGE_IN_W'($urandom);
    else if (sel >= 68) page[$urandom_range(PAGE_IN_W - 1)] ^= 1'b1;
    return page;
  endfunction

  task automatic test_directed();
    logic [PAGE_IN_W-1:0] pages [20];
    pages = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000,
              16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFE, 16'h5555, 16'hAAAA,
              16'h5555, 16'hFFFE, 16'hAAAA, 16'h0001, 16'hAAAB, 16'hAAAA};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (pages[i]) send_page(pages[i]);
    wait_drain();
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 40 == 0) refresh_hot_pages();
      // stretches without gaps inside idling phases
      if (n % 50 == 25) send_idle_pct = 0;
      if (n % 50 == 40) send_idle_pct = idle_pct;
      send_page(pick_page());
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, 190);
    run_phase(48, 0, 190);
    run_phase(0, 48, 190);
    run_phase(22, 22, 190);
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    refresh_hot_pages();
    hold_off_until = held_cycles + 200;
    for (int n = 0; n < 24; n++) send_page(pick_page());
    wait_drain();
  endtask

  // Cycle four pages through three frames: nearly every reference faults.
  task automatic test_fault_thrash();
    logic [PAGE_IN_W-1:0] base;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    base = PAGE_IN_W'($urandom);
    for (int k = 0; k < 40; k++) send_page(base + PAGE_IN_W'(k % 4));
    wait_drain();
  endtask

  initial begin
    foreach (frame_tag[i]) begin
      frame_tag[i]  = '0;
      frame_used[i] = 1'b0;
      frame_age[i]  = '0;
    end
    fault_total = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic();
    test_backpressure();
    test_fault_thrash();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
